// File: rtl/led_fade_pwm_shift_driver_defines.svh
// assertion macros used by the checker file lfp_checker.sv
// no dependencies; expects clk and rst_n in the scope of use
`ifndef LED_FADE_PWM_SHIFT_DRIVER_DEFINES_SVH
`define LED_FADE_PWM_SHIFT_DRIVER_DEFINES_SVH

// same-cycle implication
`define LFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lfp_pkg.sv
// shared constants, code values and the status slot order for the led fade driver
// no dependencies
package lfp_pkg;

  localparam int NUM_LEDS        = 20;
  localparam int NUM_STATUS_LEDS = 13;
  localparam int NUM_GATES       = 4;

  localparam int LEVEL_W   = 8;
  localparam int IDX_W     = 5;
  localparam int CMD_W     = 2;
  localparam int GATE_IN_W = 4;

  localparam int FRAME_LEN = NUM_LEDS + NUM_GATES;
  localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int ST_W      = (NUM_STATUS_LEDS > 1) ? $clog2(NUM_STATUS_LEDS) : 1;
  localparam int CNT_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

  localparam logic [LEVEL_W-1:0] STEP_RESET  = 8'd9;
  localparam logic [LEVEL_W-1:0] PHASE_RESET = 8'd3;

  localparam logic [CMD_W-1:0] CMD_STAGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [NUM_GATES-1:0] gate_vec_t;

  // status led number to led slot
  function automatic logic [IDX_W-1:0] slot_of(input logic [ST_W-1:0] st);
    logic [IDX_W-1:0] s;
    case (st)
      4'd0:    s = 5'd19;
      4'd1:    s = 5'd18;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd16;
      4'd4:    s = 5'd15;
      4'd5:    s = 5'd8;
      4'd6:    s = 5'd9;
      4'd7:    s = 5'd10;
      4'd8:    s = 5'd11;
      4'd9:    s = 5'd12;
      4'd10:   s = 5'd13;
      4'd11:   s = 5'd14;
      4'd12:   s = 5'd2;
      default: s = 5'd31;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/lfp_in_if.sv
// input channel of the led fade driver: valid/ready plus command payload
// depends on lfp_pkg
interface lfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [lfp_pkg::CMD_W-1:0]     command;
  logic [lfp_pkg::IDX_W-1:0]     led_index;
  logic [lfp_pkg::LEVEL_W-1:0]   level;
  logic [lfp_pkg::GATE_IN_W-1:0] gate_bits;

  modport source (output valid, command, led_index, level, gate_bits, input ready);
  modport sink   (input valid, command, led_index, level, gate_bits, output ready);
endinterface

// File: rtl/lfp_out_if.sv
// serial bit channel of the led fade driver: valid/ready plus data and last flag
// no dependencies
interface lfp_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last_bit;

  modport source (output valid, data_bit, last_bit, input ready);
  modport sink   (input valid, data_bit, last_bit, output ready);
endinterface

// File: rtl/led_fade_pwm_shift_driver.sv
// led fade and software pwm driver for a 24-bit shift chain
// depends on lfp_pkg, lfp_in_if and lfp_out_if
//
// Write beats (stage a status level, set a target) leave the state unchanged, and the
// block stays ready. A tick beat advances the pwm phase and sends one frame of
// 24 beats, one per cycle while the sink is ready: 20 led compare bits, then
// the gate bits inverted, gate 3 first, with last_bit on the final beat.
// Every second tick first walks the 13 status slots, one per cycle, to load
// targets and lift lower current levels, so the input stays busy through the
// walk and the frame; on these fade ticks the led fade step is applied to each
// led as its bit is sent. Ready returns once the last bit is loaded.
module led_fade_pwm_shift_driver (
  input  logic                          clk,
  input  logic                          rst_n,
  lfp_in_if.sink                        in_ch,
  lfp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lfp_pkg::LEVEL_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_STAGE, S_EMIT} state_t;

  state_t                       state_r;
  logic [lfp_pkg::ST_W-1:0]     st_cnt_r;
  logic [lfp_pkg::CNT_W-1:0]    bit_cnt_r;
  logic                         fade_r;
  logic                         parity_r;
  lfp_pkg::level_t              phase_r;
  lfp_pkg::level_t              step_r;
  lfp_pkg::gate_vec_t           gate_sh_r;
  lfp_pkg::level_t              cur_r [lfp_pkg::NUM_LEDS];
  lfp_pkg::level_t              tgt_r [lfp_pkg::NUM_LEDS];
  lfp_pkg::level_t              stg_r [lfp_pkg::NUM_STATUS_LEDS];
  logic                         out_valid_r;
  logic                         out_data_r;
  logic                         out_last_r;

  logic                         in_acc;
  logic                         out_free;
  logic                         parity_nxt;
  lfp_pkg::level_t              phase_nxt;
  logic [lfp_pkg::IDX_W-1:0]    slot;
  logic                         slot_ok;
  logic [lfp_pkg::LED_W-1:0]    slot_i;
  lfp_pkg::level_t              stg_lvl;
  logic                         is_led;
  logic [lfp_pkg::LED_W-1:0]    led_i;
  lfp_pkg::level_t              cur_lvl;
  lfp_pkg::level_t              tgt_lvl;
  lfp_pkg::level_t              stepped_nxt;
  logic                         data_nxt;
  logic                         last_nxt;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.data_bit = out_data_r;
  assign out_ch.last_bit = out_last_r;

  assign parity_nxt = ~parity_r;
  assign phase_nxt  = phase_r + step_r;

  // staging walk
  assign slot    = lfp_pkg::slot_of(st_cnt_r);
  assign slot_ok = slot < lfp_pkg::IDX_W'(lfp_pkg::NUM_LEDS);
  assign slot_i  = slot[lfp_pkg::LED_W-1:0];
  assign stg_lvl = stg_r[st_cnt_r];

  // frame emission with the fade step folded in
  assign is_led  = bit_cnt_r < lfp_pkg::CNT_W'(lfp_pkg::NUM_LEDS);
  assign led_i   = is_led ? bit_cnt_r[lfp_pkg::LED_W-1:0] : '0;
  assign cur_lvl = cur_r[led_i];
  assign tgt_lvl = tgt_r[led_i];

  always_comb begin
    stepped_nxt = cur_lvl;
    if (fade_r) begin
      if (tgt_lvl > cur_lvl) begin
        stepped_nxt = cur_lvl + 8'd1;
      end else if (tgt_lvl < cur_lvl) begin
        stepped_nxt = cur_lvl - 8'd1;
      end
    end
  end

  assign data_nxt = is_led ? (stepped_nxt > phase_r) : ~gate_sh_r[lfp_pkg::NUM_GATES-1];
  assign last_nxt = bit_cnt_r == lfp_pkg::CNT_W'(lfp_pkg::FRAME_LEN - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_cnt_r    <= '0;
      bit_cnt_r   <= '0;
      fade_r      <= 1'b0;
      parity_r    <= 1'b0;
      phase_r     <= lfp_pkg::PHASE_RESET;
      step_r      <= lfp_pkg::STEP_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < lfp_pkg::NUM_LEDS; i++) begin
        cur_r[i] <= '0;
        tgt_r[i] <= '0;
      end
      for (int i = 0; i < lfp_pkg::NUM_STATUS_LEDS; i++) begin
        stg_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.command)
              lfp_pkg::CMD_STAGE: begin
                if (in_ch.led_index < lfp_pkg::IDX_W'(lfp_pkg::NUM_STATUS_LEDS)) begin
                  stg_r[in_ch.led_index[lfp_pkg::ST_W-1:0]] <= in_ch.level;
                end
              end
              lfp_pkg::CMD_SET: begin
                if (in_ch.led_index < lfp_pkg::IDX_W'(lfp_pkg::NUM_LEDS)) begin
                  tgt_r[in_ch.led_index[lfp_pkg::LED_W-1:0]] <= in_ch.level;
                end
              end
              lfp_pkg::CMD_TICK: begin
                parity_r  <= parity_nxt;
                phase_r   <= phase_nxt;
                gate_sh_r <= lfp_pkg::gate_vec_t'(in_ch.gate_bits);
                bit_cnt_r <= '0;
                st_cnt_r  <= '0;
                fade_r    <= !parity_nxt;
                state_r   <= parity_nxt ? S_EMIT : S_STAGE;
              end
              default: begin
              end
            endcase
          end
        end
        S_STAGE: begin
          if (slot_ok) begin
            tgt_r[slot_i] <= stg_lvl;
            if (cur_r[slot_i] < stg_lvl) begin
              cur_r[slot_i] <= stg_lvl;
            end
          end
          if (st_cnt_r == lfp_pkg::ST_W'(lfp_pkg::NUM_STATUS_LEDS - 1)) begin
            state_r <= S_EMIT;
          end else begin
            st_cnt_r <= st_cnt_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= data_nxt;
            out_last_r  <= last_nxt;
            if (is_led) begin
              cur_r[led_i] <= stepped_nxt;
            end else begin
              gate_sh_r <= gate_sh_r << 1;
            end
            if (last_nxt) begin
              state_r <= S_IDLE;
            end else begin
              bit_cnt_r <= bit_cnt_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/lfp_checker.sv
// port-level checks for the led fade driver, bound to the top level
// depends on lfp_pkg and led_fade_pwm_shift_driver_defines.svh
`include "led_fade_pwm_shift_driver_defines.svh"

module lfp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [lfp_pkg::CMD_W-1:0] in_command,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_data_bit,
  input logic                      out_last_bit
);

  // stalled beat holds
  `LFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data_bit) && $stable(out_last_bit), "stalled beat changed")

  // no new item mid-frame
  `LFP_ASSERT_NOW(a_busy_frame, out_valid && !out_last_bit, !in_ready,
    "input ready while a frame is in flight")

  // a tick starts a frame and drops ready
  `LFP_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_command == lfp_pkg::CMD_TICK,
    !in_ready, "input ready right after a tick")

  // writes never stall the input
  `LFP_ASSERT_NEXT(a_write_ready, in_valid && in_ready && in_command != lfp_pkg::CMD_TICK,
    in_ready, "input stalled after a write beat")

endmodule

bind led_fade_pwm_shift_driver lfp_checker u_lfp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_command   (in_ch.command),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_data_bit (out_ch.data_bit),
  .out_last_bit (out_ch.last_bit)
);
